// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A consequent that must hold in the same cycle as its antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- rtl/mm4acc_pkg.sv -----
package mm4acc_pkg;

   localparam int DIM       = 4;
   localparam int CELLS     = 16;
   localparam int IDX_W     = 2;
   localparam int ADDR_W    = 4;
   localparam int DATA_W    = 32;
   localparam int FRAC_BITS = 16;

   localparam logic [1:0] REQ_OPERAND  = 2'd0;
   localparam logic [1:0] REQ_CURRENT  = 2'd1;
   localparam logic [1:0] REQ_MULTIPLY = 2'd2;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] cur_addr;
      logic [ADDR_W-1:0] opd_addr;
   } rd_req_type;

   typedef struct packed {
      logic              cur_en;
      logic              opd_en;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
   } wr_req_type;

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } mac_ctrl_type;

endpackage

// ----- rtl/mm4acc_chan_if.sv -----
interface mm4acc_req_if;
   logic                                      valid;
   logic                                      ready;
   logic [1:0]                                req_type;
   logic [mm4acc_pkg::IDX_W-1:0]              row_index;
   logic [mm4acc_pkg::IDX_W-1:0]              column_index;
   logic signed [mm4acc_pkg::DATA_W-1:0]      element_value;

   modport source (output valid, output req_type, output row_index, output column_index,
                   output element_value, input ready);
   modport sink   (input valid, input req_type, input row_index, input column_index,
                   input element_value, output ready);
endinterface

interface mm4acc_rsp_if;
   logic                                      valid;
   logic                                      ready;
   logic [mm4acc_pkg::IDX_W-1:0]              out_row;
   logic [mm4acc_pkg::IDX_W-1:0]              out_column;
   logic signed [mm4acc_pkg::DATA_W-1:0]      out_value;
   logic                                      last_element;

   modport source (output valid, output out_row, output out_column, output out_value,
                   output last_element, input ready);
   modport sink   (input valid, input out_row, input out_column, input out_value,
                   input last_element, output ready);
endinterface

// ----- rtl/mm4acc_store.sv -----
module mm4acc_store #(
   parameter int FRAC_BITS = mm4acc_pkg::FRAC_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mm4acc_pkg::rd_req_type               rd,
   input  mm4acc_pkg::wr_req_type               wr,
   output logic signed [mm4acc_pkg::DATA_W-1:0] cur_data,
   output logic signed [mm4acc_pkg::DATA_W-1:0] opd_data
);

   localparam int DW = mm4acc_pkg::DATA_W;
   localparam int AW = mm4acc_pkg::ADDR_W;
   localparam int IW = mm4acc_pkg::IDX_W;
   localparam logic [DW-1:0] UNIT = DW'(1) << FRAC_BITS;

   logic [DW-1:0] cur_mem [mm4acc_pkg::CELLS];
   logic [DW-1:0] opd_mem [mm4acc_pkg::CELLS];

   logic [mm4acc_pkg::CELLS-1:0] cur_vld_ff;
   logic [mm4acc_pkg::CELLS-1:0] opd_vld_ff;

   logic [DW-1:0] cur_q_ff;
   logic [DW-1:0] opd_q_ff;
   logic          cur_vq_ff;
   logic          opd_vq_ff;
   logic          diag_ff;

   always_ff @(posedge clock) begin
      if (wr.cur_en) begin
         cur_mem[wr.addr] <= wr.data;
      end
      if (wr.opd_en) begin
         opd_mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         cur_q_ff <= cur_mem[rd.cur_addr];
         opd_q_ff <= opd_mem[rd.opd_addr];
      end
   end

   // Entries never written read as their reset value: identity and zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_vld_ff <= '0;
         opd_vld_ff <= '0;
      end else begin
         if (wr.cur_en) begin
            cur_vld_ff[wr.addr] <= 1'b1;
         end
         if (wr.opd_en) begin
            opd_vld_ff[wr.addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         cur_vq_ff <= cur_vld_ff[rd.cur_addr];
         opd_vq_ff <= opd_vld_ff[rd.opd_addr];
         diag_ff   <= (rd.cur_addr[AW-1:IW] == rd.cur_addr[IW-1:0]);
      end
   end

   assign cur_data = cur_vq_ff ? cur_q_ff : (diag_ff ? UNIT : '0);
   assign opd_data = opd_vq_ff ? opd_q_ff : '0;

endmodule

// ----- rtl/mm4acc_mac.sv -----
`include "assert_macros.svh"

module mm4acc_mac #(
   parameter int FRAC_BITS = mm4acc_pkg::FRAC_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mm4acc_pkg::mac_ctrl_type             ctrl,
   input  logic signed [mm4acc_pkg::DATA_W-1:0] cur_data,
   input  logic signed [mm4acc_pkg::DATA_W-1:0] opd_data,
   output logic                                 res_valid,
   output logic [mm4acc_pkg::DATA_W-1:0]        res_value
);

   localparam int DW = mm4acc_pkg::DATA_W;
   localparam int PW = 2 * DW;

   mm4acc_pkg::mac_ctrl_type ctrl_s1_ff;
   mm4acc_pkg::mac_ctrl_type ctrl_s2_ff;
   logic                     done_ff;

   logic signed [PW-1:0] prod_in;
   logic signed [PW-1:0] prod_ff;
   logic signed [PW-1:0] term;
   logic signed [PW-1:0] acc_in;
   logic signed [PW-1:0] acc_ff;

   assign prod_in = cur_data * opd_data;
   assign term    = prod_ff >>> FRAC_BITS;
   assign acc_in  = (ctrl_s2_ff.first ? '0 : acc_ff) + term;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_s1_ff <= '0;
         ctrl_s2_ff <= '0;
         done_ff    <= 1'b0;
      end else begin
         ctrl_s1_ff <= ctrl;
         ctrl_s2_ff <= ctrl_s1_ff;
         done_ff    <= ctrl_s2_ff.valid && ctrl_s2_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_s1_ff.valid) begin
         prod_ff <= prod_in;
      end
      if (ctrl_s2_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   always_comb begin
      if (!acc_ff[PW-1] && (|acc_ff[PW-2:DW-1])) begin
         res_value = {1'b0, {(DW-1){1'b1}}};
      end else if (acc_ff[PW-1] && !(&acc_ff[PW-2:DW-1])) begin
         res_value = {1'b1, {(DW-1){1'b0}}};
      end else begin
         res_value = acc_ff[DW-1:0];
      end
   end

   assign res_valid = done_ff;

   `ASSERT_IMPLY(a_dot_starts_fresh, clock, reset, ctrl.valid && ctrl.last, $past(ctrl.valid, 3) && $past(ctrl.first, 3), "Dot product closed without its first term three cycles earlier.")

endmodule

// ----- rtl/matrix_multiply_4x4_accumulate.sv -----
// Keeps a current 4x4 matrix (identity after reset) and an operand 4x4 matrix, both signed
// Q16.16 in two 16-entry memories. A write request (operand or current element) returns
// nothing. A multiply request replaces the current matrix with current times operand and
// returns the 16 new elements in row-major order, the last one flagged. Each element is four
// multiply-accumulates issued one per cycle through a single multiplier, followed by the
// memory, multiply and accumulate pipeline stages; after every row the four results are
// written back to the current memory. The block takes no new request while a multiply runs,
// and a stall on the result side holds it. Products drop their low fraction bits (floor) and
// each finished sum saturates to 32 bits.
`include "assert_macros.svh"

module matrix_multiply_4x4_accumulate #(
   parameter int FRAC_BITS = mm4acc_pkg::FRAC_BITS
) (
   input  logic         clock,
   input  logic         reset,
   mm4acc_req_if.sink   req_in,
   mm4acc_rsp_if.source rsp_out
);

   localparam int DW = mm4acc_pkg::DATA_W;
   localparam int AW = mm4acc_pkg::ADDR_W;
   localparam int IW = mm4acc_pkg::IDX_W;
   localparam logic [IW-1:0] LAST_IDX  = IW'(mm4acc_pkg::DIM - 1);
   localparam logic [AW-1:0] LAST_ELEM = AW'(mm4acc_pkg::CELLS - 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_WAIT  = 2'd2;
   localparam logic [1:0] ST_WB    = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [AW-1:0] elem_ff, elem_in;
   logic [IW-1:0] term_ff, term_in;
   logic [IW-1:0] wb_ff, wb_in;
   logic          res_pend_ff, res_pend_in;
   logic          out_vld_ff, out_vld_in;
   logic [IW-1:0] out_row_ff;
   logic [IW-1:0] out_col_ff;
   logic [DW-1:0] out_value_ff;
   logic          out_last_ff;
   logic [DW-1:0] row_ff [mm4acc_pkg::DIM];

   logic [IW-1:0] cur_r;
   logic [IW-1:0] cur_c;
   logic          accept;
   logic          load;

   mm4acc_pkg::rd_req_type   rd;
   mm4acc_pkg::wr_req_type   wr;
   mm4acc_pkg::mac_ctrl_type ctrl;

   logic signed [DW-1:0] cur_data;
   logic signed [DW-1:0] opd_data;
   logic                 mac_valid;
   logic [DW-1:0]        mac_value;

   assign cur_r  = elem_ff[AW-1:IW];
   assign cur_c  = elem_ff[IW-1:0];
   assign accept = req_in.valid && req_in.ready;
   assign load   = (state_ff == ST_WAIT) && (mac_valid || res_pend_ff)
                   && (!out_vld_ff || rsp_out.ready);

   assign req_in.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      elem_in      = elem_ff;
      term_in      = term_ff;
      wb_in        = wb_ff;
      rd.en        = 1'b0;
      rd.cur_addr  = {cur_r, term_ff};
      rd.opd_addr  = {term_ff, cur_c};
      ctrl.valid   = 1'b0;
      ctrl.first   = (term_ff == '0);
      ctrl.last    = (term_ff == LAST_IDX);
      wr.cur_en    = accept && (req_in.req_type == mm4acc_pkg::REQ_CURRENT);
      wr.opd_en    = accept && (req_in.req_type == mm4acc_pkg::REQ_OPERAND);
      wr.addr      = {req_in.row_index, req_in.column_index};
      wr.data      = req_in.element_value;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_in.req_type == mm4acc_pkg::REQ_MULTIPLY)) begin
               state_in = ST_ISSUE;
               elem_in  = '0;
               term_in  = '0;
            end
         end
         ST_ISSUE: begin
            rd.en      = 1'b1;
            ctrl.valid = 1'b1;
            term_in    = term_ff + 1'b1;
            if (term_ff == LAST_IDX) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (load) begin
               if (cur_c == LAST_IDX) begin
                  state_in = ST_WB;
                  wb_in    = '0;
               end else begin
                  state_in = ST_ISSUE;
                  elem_in  = elem_ff + 1'b1;
               end
            end
         end
         ST_WB: begin
            wr.cur_en = 1'b1;
            wr.addr   = {cur_r, wb_ff};
            wr.data   = row_ff[wb_ff];
            wb_in     = wb_ff + 1'b1;
            if (wb_ff == LAST_IDX) begin
               elem_in  = elem_ff + 1'b1;
               state_in = (elem_ff == LAST_ELEM) ? ST_IDLE : ST_ISSUE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign res_pend_in = (mac_valid || res_pend_ff) && !load;
   assign out_vld_in  = load || (out_vld_ff && !rsp_out.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         elem_ff     <= '0;
         term_ff     <= '0;
         wb_ff       <= '0;
         res_pend_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         elem_ff     <= elem_in;
         term_ff     <= term_in;
         wb_ff       <= wb_in;
         res_pend_ff <= res_pend_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_row_ff     <= cur_r;
         out_col_ff     <= cur_c;
         out_value_ff   <= mac_value;
         out_last_ff    <= (elem_ff == LAST_ELEM);
         row_ff[cur_c]  <= mac_value;
      end
   end

   assign rsp_out.valid        = out_vld_ff;
   assign rsp_out.out_row      = out_row_ff;
   assign rsp_out.out_column   = out_col_ff;
   assign rsp_out.out_value    = out_value_ff;
   assign rsp_out.last_element = out_last_ff;

   mm4acc_store #(
      .FRAC_BITS (FRAC_BITS)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd       (rd),
      .wr       (wr),
      .cur_data (cur_data),
      .opd_data (opd_data)
   );

   mm4acc_mac #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .cur_data  (cur_data),
      .opd_data  (opd_data),
      .res_valid (mac_valid),
      .res_value (mac_value)
   );

   `ASSERT_IMPLY(a_no_result_overrun, clock, reset, mac_valid, !res_pend_ff, "A new dot product finished before the previous one was taken.")
   `ASSERT_IMPLY(a_wb_no_read, clock, reset, wr.cur_en, !rd.en, "Current matrix written while a read is issued.")
   `ASSERT_ALWAYS(a_idle_clean, clock, reset, (state_ff != ST_IDLE) || (!res_pend_ff && !mac_valid), "Block idle with a dot product still in flight.")

endmodule
